// ----- rtl/kmi_pkg.sv -----
// ============================================================================
// kmi_pkg
// Shared types and codes of the keyed map (insert and lookup).
// ============================================================================
package kmi_pkg;

    // Default number of entries, one per cell of the chain.
    localparam int KMI_CAPACITY = 256;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;

    // Opcodes of an input beat.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // One request as it travels down the chain. Once done is set, the
    // status and value are final and later cells only pass it along.
    typedef struct packed {
        logic                valid;
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  vout;
    } kmi_item_t;

endpackage

// ----- rtl/kmi_cell.sv -----
// ============================================================================
// kmi_cell
// One map entry plus one pipeline slot of the request chain.
// ============================================================================
module kmi_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  kmi_pkg::kmi_item_t item_in,
    output kmi_pkg::kmi_item_t item_out,
    output logic              entry_valid
);
    import kmi_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               valid_reg;
    kmi_item_t          item_reg;
    kmi_item_t          item_next;
    logic               match;
    logic               entry_write;

    // Entries fill from the head of the chain, so the first empty cell a
    // request meets ends its search: nothing valid lies beyond it.
    always_comb begin
        item_next   = item_in;
        entry_write = 1'b0;
        match       = valid_reg && (key_reg == item_in.key);
        if (item_in.valid && !item_in.done) begin
            if (match) begin
                item_next.done = 1'b1;
                if (item_in.op == OP_INSERT) begin
                    item_next.status = ST_DUPLICATE;
                end else begin
                    item_next.status = ST_HIT;
                    item_next.vout   = value_reg;
                end
            end else if (!valid_reg) begin
                item_next.done = 1'b1;
                if (item_in.op == OP_INSERT) begin
                    entry_write      = 1'b1;
                    item_next.status = ST_INSERTED;
                end else begin
                    item_next.status = ST_MISS;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            item_reg.valid <= 1'b0;
        end else if (advance) begin
            item_reg <= item_next;
            if (entry_write) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && entry_write) begin
            key_reg   <= item_in.key;
            value_reg <= item_in.value;
        end
    end

    assign item_out    = item_reg;
    assign entry_valid = valid_reg;

endmodule

// ----- rtl/kmi_out_stage.sv -----
// ============================================================================
// kmi_out_stage
// Result register at the tail of the chain; lets the chain move on while a
// finished result waits for the sink.
// ============================================================================
module kmi_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  kmi_pkg::kmi_item_t               tail,
    output logic                             advance,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [kmi_pkg::STATUS_W-1:0]     m_status,
    output logic [kmi_pkg::VALUE_W-1:0]      m_value_out
);
    import kmi_pkg::*;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  value_reg;

    // The chain stalls only when both the tail and this register hold a
    // result and the sink is not taking one.
    assign advance = !tail.valid || !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && tail.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tail.valid) begin
            status_reg <= tail.status;
            value_reg  <= tail.vout;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = status_reg;
    assign m_value_out = value_reg;

endmodule

// ----- rtl/keyed_map_insert_lookup.sv -----
// ============================================================================
// keyed_map_insert_lookup
// Fixed-capacity map from 64-bit keys to 64-bit values, built as a chain of
// entry cells through which requests flow one cell per cycle while it moves.
// ============================================================================
//
//   Channel   Direction  Ports                              Meaning
//   s_        in         s_opcode, s_key, s_value_in        insert or lookup
//   m_        out        m_status, m_value_out              one result per beat
//
// A beat is accepted on s_ every cycle the chain moves; its result passes
// through every cell register and then the result register before it
// appears on m_, so the sustained rate is one beat per cycle while m_ready
// does not stall the chain. Each cell compares one stored key.
// Reset (aresetn low, synchronous) clears the entry valid marks and the
// pipeline valid bits at once; no clearing pass is needed.
// The chain stalls as a whole only while the result register and the tail
// cell both hold a result and m_ready is low.
//
// Each cell holds one entry. Entries fill strictly from cell 0 upward and are
// never removed, so the valid entries form a prefix of the chain. A request
// compares its key at every valid cell; the first empty cell it meets ends
// the search: an insert claims that cell, a lookup reports a miss. Requests
// keep their order, so a later request always sees every entry that an
// earlier one wrote. A request that reaches the tail unresolved found every
// cell full and no match: its preset status (full for an insert) stands.
// ============================================================================
module keyed_map_insert_lookup #(
    parameter int CAPACITY = kmi_pkg::KMI_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [kmi_pkg::KEY_W-1:0]     s_key,
    input  logic [kmi_pkg::VALUE_W-1:0]   s_value_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kmi_pkg::STATUS_W-1:0]  m_status,
    output logic [kmi_pkg::VALUE_W-1:0]   m_value_out
);
    import kmi_pkg::*;

    kmi_item_t             chain [CAPACITY+1];
    kmi_item_t             head_item;
    logic [CAPACITY-1:0]   entry_valid;
    logic                  advance;

    // Inject a new request at the head. Its status is preset to the answer
    // it gets if no cell resolves it.
    always_comb begin
        head_item.valid  = s_valid;
        head_item.op     = s_opcode;
        head_item.key    = s_key;
        head_item.value  = s_value_in;
        head_item.done   = 1'b0;
        head_item.status = (s_opcode == OP_INSERT) ? ST_FULL : ST_MISS;
        head_item.vout   = '0;
    end

    assign chain[0] = head_item;
    assign s_ready  = advance;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        kmi_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (advance),
            .item_in     (chain[i]),
            .item_out    (chain[i+1]),
            .entry_valid (entry_valid[i])
        );
    end

    kmi_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tail        (chain[CAPACITY]),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_out (m_value_out)
    );

    // Valid entries always form a prefix starting at cell 0.
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (entry_valid & (entry_valid + CAPACITY'(1))) == '0)
        else $error("entry valid marks are not a prefix of the chain");

    // An entry, once written, is never lost.
    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((entry_valid & $past(entry_valid)) == $past(entry_valid)))
        else $error("a valid entry was cleared");

    // Only a lookup hit carries a nonzero value.
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_HIT) |-> (m_value_out == '0))
        else $error("nonzero value on a result other than a hit");

    // Result status is always a defined code.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_FULL))
        else $error("undefined result status");

endmodule

// ----- tb/keyed_map_insert_lookup_test.sv -----
// ============================================================================
// keyed_map_insert_lookup_test
// Self-checking bench for the fixed-capacity keyed map. A small scoreboard
// mirrors the map's contents, predicts the status and value of every accepted
// request, and compares each result beat in order against that prediction.
// ============================================================================
`timescale 1ns / 100ps

module keyed_map_insert_lookup_test;

    localparam int MAP_CAP = kmi_pkg::KMI_CAPACITY;

    // Random stimulus length. The last stretch of it runs with no idling.
    localparam int RANDOM_BEATS = 1880;
    localparam int QUIET_TAIL   = 200;

    // Upper bound on the length of an idle burst on either side.
    localparam int BURST_MAX = 17;

    // At most this many mismatch lines are printed.
    localparam int REPORT_CAP = 20;

    typedef struct {
        logic [kmi_pkg::STATUS_W-1:0] status;
        logic [kmi_pkg::VALUE_W-1:0]  vout;
    } map_answer_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the stored pairs in arrival order;
    // since entries are never removed, a flat list with a linear search is an
    // exact picture of the map, whatever layout the block uses inside.
    // ------------------------------------------------------------------------
    class map_scoreboard;
        logic [kmi_pkg::KEY_W-1:0]   keys_held   [MAP_CAP];
        logic [kmi_pkg::VALUE_W-1:0] values_held [MAP_CAP];
        int unsigned                 entries;
        map_answer_t                 awaited [$];
        int unsigned                 errors;
        int unsigned                 reported;
        int unsigned                 seen [5];

        function new();
            entries  = 0;
            errors   = 0;
            reported = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        // Work out the answer to one accepted request and update the copy.
        function void note_request(logic op, logic [kmi_pkg::KEY_W-1:0] key,
                                   logic [kmi_pkg::VALUE_W-1:0] value);
            map_answer_t ans;
            int          slot;
            slot     = -1;
            ans.vout = '0;
            for (int i = 0; i < int'(entries); i++) begin
                if (keys_held[i] == key) begin
                    slot = i;
                    break;
                end
            end
            if (op == kmi_pkg::OP_INSERT) begin
                if (slot >= 0) begin
                    ans.status = kmi_pkg::ST_DUPLICATE;
                end else if (entries >= MAP_CAP) begin
                    ans.status = kmi_pkg::ST_FULL;
                end else begin
                    keys_held[entries]   = key;
                    values_held[entries] = value;
                    entries++;
                    ans.status = kmi_pkg::ST_INSERTED;
                end
            end else begin
                if (slot >= 0) begin
                    ans.status = kmi_pkg::ST_HIT;
                    ans.vout   = values_held[slot];
                end else begin
                    ans.status = kmi_pkg::ST_MISS;
                end
            end
            awaited.push_back(ans);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (reported < REPORT_CAP) begin
                reported++;
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want,
                         got);
            end
        endfunction

        // Compare one result beat with the oldest pending answer.
        function void check_answer(logic [kmi_pkg::STATUS_W-1:0] status,
                                   logic [kmi_pkg::VALUE_W-1:0] vout);
            map_answer_t want;
            if (awaited.size() == 0) begin
                flag("unexpected result beat, status", 64'h0, 64'(status));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) flag("status", 64'(want.status), 64'(status));
            if (vout !== want.vout) flag("value_out", want.vout, vout);
            seen[want.status]++;
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_opcode;
    logic [kmi_pkg::KEY_W-1:0]     s_key;
    logic [kmi_pkg::VALUE_W-1:0]   s_value_in;
    logic                          m_valid;
    logic                          m_ready;
    logic [kmi_pkg::STATUS_W-1:0]  m_status;
    logic [kmi_pkg::VALUE_W-1:0]   m_value_out;

    map_scoreboard               sb;
    bit                          tail_quiet;
    int                          beats_sent;
    int                          ready_hold;
    logic [kmi_pkg::KEY_W-1:0]   sent_keys [$];

    keyed_map_insert_lookup dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_key       (s_key),
        .s_value_in  (s_value_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_out (m_value_out)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hard limit on the run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. m_ready changes on the falling edge; it drops for bursts
    // up to BURST_MAX long now and then, except in calm stretches and the tail.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else if (!tail_quiet && ((beats_sent / 170) % 3 != 2)
                     && $urandom_range(0, 99) < 10) begin
            ready_hold = $urandom_range(1, BURST_MAX) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result beat is taken at the rising edge where valid meets ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_answer(m_status, m_value_out);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random value, with the all-zero and all-one patterns mixed in.
    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return rand64();
    endfunction

    function automatic logic [63:0] known_key();
        return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Request side. One call moves one beat: an optional idle burst first,
    // then the payload is set on the falling edge and held until accepted.
    // The scoreboard hears of the beat at the edge that accepts it, so its
    // order is the block's order.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic op, input logic [63:0] key,
                             input logic [63:0] value);
        int gap;
        gap = 0;
        if (!tail_quiet && ((beats_sent / 150) % 3 != 1) && $urandom_range(0, 99) < 20)
            gap = $urandom_range(1, BURST_MAX);
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_key      <= key;
        s_value_in <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, key, value);
        beats_sent++;
        if (op == kmi_pkg::OP_INSERT) sent_keys.push_back(key);
    endtask

    // Short directed opening: extreme keys and values, both operations,
    // duplicates (value kept, zero returned), misses and near misses.
    task automatic run_directed();
        send_beat(kmi_pkg::OP_LOOKUP, 64'h0, 64'h0);
        send_beat(kmi_pkg::OP_INSERT, 64'h0, '1);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h0, 64'h0);
        send_beat(kmi_pkg::OP_INSERT, '1, 64'h0);
        send_beat(kmi_pkg::OP_LOOKUP, '1, '1);
        send_beat(kmi_pkg::OP_INSERT, 64'h0, 64'h5);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h0, 64'h0);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h1, '1);
        send_beat(kmi_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        send_beat(kmi_pkg::OP_INSERT, 64'h7fff_ffff_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h7fff_ffff_ffff_ffff, 64'h0);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001, 64'h0);
        send_beat(kmi_pkg::OP_LOOKUP, 64'hffff_ffff_ffff_fffe, 64'h0);
        send_beat(kmi_pkg::OP_INSERT, 64'h1, 64'h0123_4567_89ab_cdef);
        send_beat(kmi_pkg::OP_INSERT, 64'h1, 64'hfedc_ba98_7654_3210);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h1, 64'h0);
        send_beat(kmi_pkg::OP_INSERT, '1, '1);
        send_beat(kmi_pkg::OP_LOOKUP, '1, 64'h0);
        send_beat(kmi_pkg::OP_LOOKUP, 64'h2, 64'h0);
    endtask

    // Random part. About a third of the beats insert fresh keys, so the map
    // fills up partway through and the rest of the run sees full refusals,
    // duplicates against a full map and hits on the oldest entries. Near
    // misses differ from a stored key in one bit.
    task automatic run_random();
        int                r;
        logic [63:0]       key;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            tail_quiet = (n >= RANDOM_BEATS - QUIET_TAIL);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                key = rand64();
                send_beat(kmi_pkg::OP_INSERT, key, pick_value());
            end else if (r < 35) begin
                key = known_key() ^ (64'h1 << $urandom_range(0, 63));
                send_beat(kmi_pkg::OP_INSERT, key, pick_value());
            end else if (r < 50) begin
                send_beat(kmi_pkg::OP_INSERT, known_key(), pick_value());
            end else if (r < 80) begin
                send_beat(kmi_pkg::OP_LOOKUP, known_key(), pick_value());
            end else if (r < 92) begin
                send_beat(kmi_pkg::OP_LOOKUP, rand64(), pick_value());
            end else begin
                key = known_key() ^ (64'h1 << $urandom_range(0, 63));
                send_beat(kmi_pkg::OP_LOOKUP, key, pick_value());
            end
        end
    endtask

    initial begin
        sb         = new();
        tail_quiet = 1'b0;
        beats_sent = 0;
        ready_hold = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_opcode   = kmi_pkg::OP_INSERT;
        s_key      = '0;
        s_value_in = '0;
        m_ready    = 1'b0;

        // Reset is held low from the start and released on a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random();
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain: every answer must arrive, then the chain gets its full
        // length again so that any stray beat behind them shows up.
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (MAP_CAP + 32) @(posedge aclk);

        $display("Run covered %0d beats; the map held %0d of %0d entries at the end.",
                 beats_sent, sb.entries, MAP_CAP);
        $display("Results: %0d inserted, %0d duplicate, %0d hit, %0d miss, %0d full.",
                 sb.seen[kmi_pkg::ST_INSERTED], sb.seen[kmi_pkg::ST_DUPLICATE],
                 sb.seen[kmi_pkg::ST_HIT], sb.seen[kmi_pkg::ST_MISS],
                 sb.seen[kmi_pkg::ST_FULL]);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/kmi_pkg.sv
rtl/kmi_cell.sv
rtl/kmi_out_stage.sv
rtl/keyed_map_insert_lookup.sv
tb/keyed_map_insert_lookup_test.sv
